// ===== hw/rtl/hhwc_pkg.sv =====
// ---------------------------------------------------------------------------
// hhwc_pkg
// Types and character constants for the HTTP header whitespace
// canonicaliser.
// ---------------------------------------------------------------------------
package hhwc_pkg;

    // Scanner mode
    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,   // plain text
        MODE_SPACE = 2'd1,   // inside a space/tab run, its space already sent
        MODE_BREAK = 2'd2,   // inside a CR/LF run, nothing sent yet
        MODE_DONE  = 2'd3    // block finished
    } t_mode;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_SUCCESS = 2'd1,
        KIND_FAILURE = 2'd2
    } t_kind;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    // Most results one input word can cause (CR, LF, byte)
    localparam int unsigned MAX_RESULTS = 3;

endpackage

// ===== hw/rtl/http_header_whitespace_canonicalizer.sv =====
// ---------------------------------------------------------------------------
// http_header_whitespace_canonicalizer
// Folds header whitespace: space/tab runs and continuations to one space,
// line breaks to CRLF; a double break, NUL or end of input ends the block.
// ---------------------------------------------------------------------------
// A word waits in the input register; results go out via the output register.
// Throughput: one input word per cycle unless the output stalls; a word
// ending a held line break emits three results, holding the input register.
// Reset (synchronous, active low) returns the scanner to text mode with the
// break flags clear and empties the input and output registers.
module http_header_whitespace_canonicalizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,    // end_of_input
    // Result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic [1:0] o_m_tuser,    // [1:0] result_kind
    output logic       o_m_tlast     // last_of_run
);
    import hhwc_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    // Scanner state
    t_mode      r_mode, n_mode;
    logic       r_seen_cr, n_seen_cr;
    logic       r_seen_lf, n_seen_lf;

    // Result index within the current input word
    logic [1:0] r_idx;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_kind      r_out_kind;
    logic       r_out_last;

    // Decode of the held word
    logic       is_sp, is_cr, is_lf, is_end;
    logic [1:0] n_count;
    logic [7:0] res_byte [MAX_RESULTS];
    t_kind      res_kind [MAX_RESULTS];
    logic [7:0] sel_byte;
    t_kind      sel_kind;
    logic       sel_last;
    logic       out_load;
    logic       emit;
    logic       consume;

    assign is_sp  = (r_in_byte == CHAR_SP) || (r_in_byte == CHAR_TAB);
    assign is_cr  = (r_in_byte == CHAR_CR);
    assign is_lf  = (r_in_byte == CHAR_LF);
    assign is_end = r_in_eoi || (r_in_byte == CHAR_NUL);

    // Results and next state for the held word
    always_comb begin
        n_count     = 2'd0;
        n_mode      = r_mode;
        n_seen_cr   = r_seen_cr;
        n_seen_lf   = r_seen_lf;
        res_byte[0] = CHAR_NUL;
        res_byte[1] = CHAR_LF;
        res_byte[2] = r_in_byte;
        res_kind[0] = KIND_DATA;
        res_kind[1] = KIND_DATA;
        res_kind[2] = KIND_DATA;
        if (r_mode == MODE_DONE) begin
            n_count = 2'd0;
        end else if (is_end) begin
            n_count     = 2'd1;
            res_kind[0] = KIND_FAILURE;
            n_mode      = MODE_DONE;
            n_seen_cr   = 1'b0;
            n_seen_lf   = 1'b0;
        end else if (is_cr || is_lf) begin
            if (r_mode == MODE_BREAK && ((is_cr && r_seen_cr) || (is_lf && r_seen_lf))) begin
                // second CR or LF in one break run: terminator
                n_count     = 2'd1;
                res_kind[0] = KIND_SUCCESS;
                n_mode      = MODE_DONE;
                n_seen_cr   = 1'b0;
                n_seen_lf   = 1'b0;
            end else begin
                n_seen_cr = ((r_mode == MODE_BREAK) && r_seen_cr) || is_cr;
                n_seen_lf = ((r_mode == MODE_BREAK) && r_seen_lf) || is_lf;
                n_mode    = MODE_BREAK;
            end
        end else if (is_sp) begin
            // space run, or fold of a held break
            n_count     = (r_mode == MODE_SPACE) ? 2'd0 : 2'd1;
            res_byte[0] = CHAR_SP;
            n_mode      = MODE_SPACE;
            n_seen_cr   = 1'b0;
            n_seen_lf   = 1'b0;
        end else begin
            if (r_mode == MODE_BREAK) begin
                // held break goes out as CRLF ahead of the byte
                n_count     = 2'd3;
                res_byte[0] = CHAR_CR;
            end else begin
                n_count     = 2'd1;
                res_byte[0] = r_in_byte;
            end
            n_mode    = MODE_TEXT;
            n_seen_cr = 1'b0;
            n_seen_lf = 1'b0;
        end
    end

    // Pick the result for the current index
    always_comb begin
        case (r_idx)
            2'd0:    begin sel_byte = res_byte[0]; sel_kind = res_kind[0]; end
            2'd1:    begin sel_byte = res_byte[1]; sel_kind = res_kind[1]; end
            2'd2:    begin sel_byte = res_byte[2]; sel_kind = res_kind[2]; end
            default: begin sel_byte = res_byte[0]; sel_kind = res_kind[0]; end
        endcase
        sel_last = (r_idx == (n_count - 2'd1));
    end

    // Handshake control
    assign out_load   = !r_out_valid || i_m_tready;
    assign emit       = r_in_valid && (n_count != 2'd0) && out_load;
    assign consume    = r_in_valid && ((n_count == 2'd0) || (emit && sel_last));
    assign o_s_tready = !r_in_valid || consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_eoi  <= i_s_tlast;
        end
    end

    // Scanner state and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TEXT;
            r_seen_cr <= 1'b0;
            r_seen_lf <= 1'b0;
            r_idx     <= 2'd0;
        end else begin
            if (consume) begin
                r_mode    <= n_mode;
                r_seen_cr <= n_seen_cr;
                r_seen_lf <= n_seen_lf;
                r_idx     <= 2'd0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_kind <= sel_kind;
            r_out_last <= sel_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== tb/sv/hhwc_checker.sv =====
// ---------------------------------------------------------------------------
// hhwc_checker
// Watches both streams of the header whitespace canonicaliser, works out the
// canonical result words for every accepted input word, and compares them,
// field by field and in order, with the words the block delivers.
// ---------------------------------------------------------------------------
module hhwc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,    // end_of_input
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] out_byte
    input  logic [1:0] i_m_tuser,    // [1:0] result_kind
    input  logic       i_m_tlast,    // last_of_run
    output int         o_fail_count,
    output int         o_pending
);
    import hhwc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    // Scanner state as the block should hold it
    t_mode   scan_mode;
    logic    cr_seen;
    logic    lf_seen;
    t_result canon_q [$];
    int      fails;

    task automatic report_mismatch(input string what);
        $display("[%0t] hhwc mismatch: %s", $time, what);
        fails++;
    endtask

    // Works out the result words caused by one input word
    task automatic canonicalise_word(input logic [7:0] b, input logic eoi);
        t_result res [MAX_RESULTS];
        int      n;
        logic    is_sp;
        logic    is_brk;
        n      = 0;
        is_sp  = (b == CHAR_SP) || (b == CHAR_TAB);
        is_brk = (b == CHAR_CR) || (b == CHAR_LF);
        if (scan_mode == MODE_DONE) begin
            // block over, word ignored
        end else if (eoi || b == CHAR_NUL) begin
            res[n++]  = '{data: 8'h00, kind: KIND_FAILURE, last: 1'b0};
            scan_mode = MODE_DONE;
            cr_seen   = 1'b0;
            lf_seen   = 1'b0;
        end else if (is_brk) begin
            if (scan_mode == MODE_BREAK &&
                    ((b == CHAR_CR && cr_seen) || (b == CHAR_LF && lf_seen))) begin
                // repeated break character: terminator
                res[n++]  = '{data: 8'h00, kind: KIND_SUCCESS, last: 1'b0};
                scan_mode = MODE_DONE;
                cr_seen   = 1'b0;
                lf_seen   = 1'b0;
            end else begin
                if (scan_mode != MODE_BREAK) begin
                    cr_seen = 1'b0;
                    lf_seen = 1'b0;
                end
                if (b == CHAR_CR) cr_seen = 1'b1;
                else lf_seen = 1'b1;
                scan_mode = MODE_BREAK;
            end
        end else if (is_sp) begin
            if (scan_mode != MODE_SPACE)
                res[n++] = '{data: CHAR_SP, kind: KIND_DATA, last: 1'b0};
            scan_mode = MODE_SPACE;
            cr_seen   = 1'b0;
            lf_seen   = 1'b0;
        end else begin
            // held break goes out as CRLF ahead of the byte
            if (scan_mode == MODE_BREAK) begin
                res[n++] = '{data: CHAR_CR, kind: KIND_DATA, last: 1'b0};
                res[n++] = '{data: CHAR_LF, kind: KIND_DATA, last: 1'b0};
            end
            res[n++]  = '{data: b, kind: KIND_DATA, last: 1'b0};
            scan_mode = MODE_TEXT;
            cr_seen   = 1'b0;
            lf_seen   = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            canon_q.push_back(res[i]);
        end
    endtask

    // Compares one delivered word with the oldest expectation
    task automatic check_word(input logic [7:0] d, input logic [1:0] k, input logic l);
        t_result want;
        if (canon_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word data=%h kind=%0d last=%b", d, k, l));
        end else begin
            want = canon_q.pop_front();
            if (k != want.kind)
                report_mismatch($sformatf("result_kind got %0d want %0d", k, want.kind));
            if (d != want.data)
                report_mismatch($sformatf("out_byte got %h want %h", d, want.data));
            if (l != want.last)
                report_mismatch($sformatf("last_of_run got %b want %b", l, want.last));
        end
    endtask

    // Input side first, so a same-edge result would already be expected
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_mode = MODE_TEXT;
            cr_seen   = 1'b0;
            lf_seen   = 1'b0;
            canon_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                canonicalise_word(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_word(i_m_tdata, i_m_tuser, i_m_tlast);
        end
        o_pending    <= canon_q.size();
        o_fail_count <= fails;
    end

    initial begin
        fails = 0;
    end

endmodule

// ===== tb/sv/http_header_whitespace_canonicalizer_tb.sv =====
// ---------------------------------------------------------------------------
// http_header_whitespace_canonicalizer_tb
// Feeds one header block through the canonicaliser: a directed opening over
// byte extremes, space runs, every break form and folding, then well-formed
// random header text, then a randomly chosen ending and a few words that the
// finished block must ignore. Sender bursts and receiver stalls vary, with
// one long receiver hold-off; the checker module judges every result word.
// ---------------------------------------------------------------------------
module http_header_whitespace_canonicalizer_tb;
    import hhwc_pkg::*;

    localparam int RANDOM_WORDS = 180;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int HOLD_START   = 120;
    localparam int HOLD_CYCLES  = 100;

    // Directed opening: extremes, runs, breaks, folds
    localparam logic [7:0] DIRECTED_BYTES [29] = '{
        8'h41, 8'h01, 8'hFF, CHAR_SP, CHAR_TAB, CHAR_SP, 8'h62,
        CHAR_CR, CHAR_LF, 8'h63,                    // CRLF then text
        CHAR_LF, CHAR_CR, CHAR_SP, CHAR_TAB, 8'h64, // LFCR fold
        CHAR_SP, CHAR_CR, 8'h65,                    // space then break
        CHAR_LF, CHAR_TAB, CHAR_SP, CHAR_LF, CHAR_SP, 8'h67, // fold after space
        CHAR_CR, 8'h68,                             // lone CR
        CHAR_LF, 8'h80, 8'h7F                       // lone LF
    };

    typedef enum int {
        END_CRLF_CR,
        END_CR_CR,
        END_LF_LF,
        END_LFCR_LF,
        END_EOI,
        END_NUL
    } t_ending;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    int         fail_count;
    int         pending;
    int         cycles;
    int         burst_left;
    logic       gen_cr;
    logic       gen_lf;

    http_header_whitespace_canonicalizer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    hhwc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** http_header_whitespace_canonicalizer: FAILED **");
            $finish;
        end
    end

    // Offers one word, idling first if the burst is used up
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Plain header byte: anything but NUL, space, tab, CR, LF
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CHAR_SP || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    // Random header byte that never forms a terminator
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)      b = text_byte();
        else if (pick < 65) b = CHAR_SP;
        else if (pick < 75) b = CHAR_TAB;
        else if (pick < 87) b = CHAR_CR;
        else                b = CHAR_LF;
        // steer away from a repeated break character
        if (b == CHAR_CR && gen_cr) b = gen_lf ? text_byte() : CHAR_LF;
        else if (b == CHAR_LF && gen_lf) b = gen_cr ? text_byte() : CHAR_CR;
        if (b == CHAR_CR)      gen_cr = 1'b1;
        else if (b == CHAR_LF) gen_lf = 1'b1;
        else begin
            gen_cr = 1'b0;
            gen_lf = 1'b0;
        end
        return b;
    endfunction

    // Stimulus and verdict
    initial begin
        t_ending ending;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tlast    <= 1'b0;
        rst_n      <= 1'b0;
        burst_left = 0;
        gen_cr     = 1'b0;
        gen_lf     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_BYTES[i])
            send_word(DIRECTED_BYTES[i], 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++)
            send_word(body_byte(), 1'b0);

        // close any open break, then end the block
        send_word(8'h5A, 1'b0);
        ending = t_ending'($urandom_range(0, 5));
        case (ending)
            END_CRLF_CR: begin
                send_word(CHAR_CR, 1'b0);
                send_word(CHAR_LF, 1'b0);
                send_word(CHAR_CR, 1'b0);
            end
            END_CR_CR: begin
                send_word(CHAR_CR, 1'b0);
                send_word(CHAR_CR, 1'b0);
            end
            END_LF_LF: begin
                send_word(CHAR_LF, 1'b0);
                send_word(CHAR_LF, 1'b0);
            end
            END_LFCR_LF: begin
                send_word(CHAR_LF, 1'b0);
                send_word(CHAR_CR, 1'b0);
                send_word(CHAR_LF, 1'b0);
            end
            END_EOI: begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                send_word(CHAR_NUL, 1'b0);
            end
        endcase

        // finished block must stay silent
        send_word(text_byte(), 1'b1);
        send_word(CHAR_NUL, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_word(CHAR_SP, 1'b1);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("** http_header_whitespace_canonicalizer: PASSED **");
        else
            $display("** http_header_whitespace_canonicalizer: FAILED **");
        $finish;
    end

    // Receiver: shifting stall patterns plus one long hold-off
    initial begin
        t_stall stall;
        int     rx_cycle;
        m_tready <= 1'b0;
        rx_cycle = 0;
        stall    = STALL_NONE;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_cycle % 32 == 0)
                stall = t_stall'($urandom_range(0, 3));
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else begin
                case (stall)
                    STALL_NONE:     m_tready <= 1'b1;
                    STALL_HALF:     m_tready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
                    default:        m_tready <= (rx_cycle % 4 != 3);
                endcase
            end
            rx_cycle++;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/hhwc_pkg.sv
hw/rtl/http_header_whitespace_canonicalizer.sv
tb/sv/hhwc_checker.sv
tb/sv/http_header_whitespace_canonicalizer_tb.sv
